@@ design/ffba_pkg.sv @@
`default_nettype none

package ffba_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W   = 21;
  localparam int START_W  = 20;
  localparam int STATUS_W = 3;

  // Default number of block table entries.
  localparam int MAX_BLOCKS = 64;

  // Header bytes in front of every block, and the size of the heap.
  localparam logic [ADDR_W-1:0] HDR_BYTES      = 21'd24;
  localparam logic [ADDR_W-1:0] HEAP_BYTES     = 21'd1048576;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 21'd1048576;

  // Block tags.
  localparam logic [1:0] TAG_FRESH  = 2'd1;
  localparam logic [1:0] TAG_REUSED = 2'd2;
  localparam logic [1:0] TAG_FREED  = 2'd3;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_EXHAUSTED = 3'd2,
    ST_FULL      = 3'd3,
    ST_BADPTR    = 3'd4
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   size;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   address_out;
    status_t             status;
    logic                moved;
    logic [ADDR_W-1:0]   copy_length;
  } rsp_t;

  // Table write operations issued by the controller.
  typedef enum logic [2:0] {
    WR_NONE      = 3'd0,
    WR_SPLIT_OLD = 3'd1,
    WR_SPLIT_NEW = 3'd2,
    WR_MARK      = 3'd3,
    WR_LINK      = 3'd4,
    WR_APPEND    = 3'd5,
    WR_RELEASE   = 3'd6
  } wr_kind_t;

  typedef enum logic {
    MODE_FIND = 1'b0,
    MODE_FIT  = 1'b1
  } walk_mode_t;

  typedef struct packed {
    logic       load;
    logic       walk_init;
    walk_mode_t walk_mode;
    logic       walk;
    logic       save_old;
    wr_kind_t   wr;
    logic       set_status;
    status_t    status_code;
    logic       keep_addr;
    logic       set_moved;
  } cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    size_zero;
    logic    addr_null;
    logic    list_valid;
    logic    walk_done;
    logic    found;
    logic    block_ok;
    logic    fits_old;
    logic    can_split;
    logic    table_full;
    logic    heap_short;
  } stat_t;

endpackage

`default_nettype wire

@@ design/ffba_ram.sv @@
`default_nettype none

module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/ffba_datapath.sv @@
`default_nettype none

module ffba_datapath #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire ffba_pkg::req_t                req,
  input  wire logic                          cfg_we,
  input  wire logic [ffba_pkg::ADDR_W-1:0]   cfg_wdata,
  input  wire ffba_pkg::cmd_t                cmd,
  output      ffba_pkg::stat_t               stat,
  output      ffba_pkg::rsp_t                rsp
);

  localparam int AddrW  = ffba_pkg::ADDR_W;
  localparam int StartW = ffba_pkg::START_W;
  localparam int IdxW   = $clog2(MAX_BLOCKS);
  localparam int CntW   = $clog2(MAX_BLOCKS + 1);

  // Architectural state.
  ffba_pkg::req_t        req_q;
  logic [AddrW-1:0]      heap_limit;
  logic                  list_valid;
  logic [IdxW-1:0]       tail_idx;
  logic [CntW-1:0]       slot_count;
  logic [AddrW-1:0]      break_offset;

  // Walk state and the entry it found.
  ffba_pkg::walk_mode_t  mode;
  logic [IdxW-1:0]       cur_idx;
  logic                  found;
  logic [IdxW-1:0]       f_idx;
  logic [StartW-1:0]     f_start;
  logic [AddrW-1:0]      f_size;
  logic                  f_free;
  logic [1:0]            f_tag;
  logic [IdxW-1:0]       f_link;
  logic [IdxW-1:0]       o_idx;
  logic [AddrW-1:0]      o_size;

  ffba_pkg::rsp_t        res;

  // Table memories.
  logic                  we_start, we_size, we_flag, we_link;
  logic [IdxW-1:0]       waddr, raddr;
  logic [StartW-1:0]     w_start, q_start;
  logic [AddrW-1:0]      w_size, q_size;
  logic [2:0]            w_flag, q_flag;
  logic [IdxW-1:0]       w_link, q_link;

  logic                  hit;
  logic                  at_tail;
  logic [IdxW-1:0]       slot_idx;
  logic [AddrW-1:0]      eff_limit;
  logic [AddrW+1:0]      brk_end;
  logic [AddrW:0]        split_need;
  logic [AddrW-1:0]      split_start;
  logic [AddrW-1:0]      rem_size;
  logic [AddrW-1:0]      grant_found;
  logic [AddrW-1:0]      grant_break;
  logic [AddrW-1:0]      q_data_addr;

  ffba_ram #(.WIDTH(StartW), .DEPTH(MAX_BLOCKS)) u_start_ram (
    .clk(clk), .we(we_start), .waddr(waddr), .wdata(w_start), .raddr(raddr), .rdata(q_start)
  );
  ffba_ram #(.WIDTH(AddrW), .DEPTH(MAX_BLOCKS)) u_size_ram (
    .clk(clk), .we(we_size), .waddr(waddr), .wdata(w_size), .raddr(raddr), .rdata(q_size)
  );
  ffba_ram #(.WIDTH(3), .DEPTH(MAX_BLOCKS)) u_flag_ram (
    .clk(clk), .we(we_flag), .waddr(waddr), .wdata(w_flag), .raddr(raddr), .rdata(q_flag)
  );
  ffba_ram #(.WIDTH(IdxW), .DEPTH(MAX_BLOCKS)) u_link_ram (
    .clk(clk), .we(we_link), .waddr(waddr), .wdata(w_link), .raddr(raddr), .rdata(q_link)
  );

  assign slot_idx    = slot_count[IdxW-1:0];
  assign q_data_addr = {{(AddrW-StartW){1'b0}}, q_start} + ffba_pkg::HDR_BYTES;
  assign hit         = (mode == ffba_pkg::MODE_FIT) ?
                       (q_flag[2] && (q_size >= req_q.size)) :
                       (q_data_addr == req_q.address);
  assign at_tail     = (cur_idx == tail_idx);

  // Follow the link as soon as the entry comes out of the memory.
  assign raddr = cmd.walk ? q_link : '0;

  assign eff_limit   = (heap_limit < ffba_pkg::HEAP_BYTES) ? heap_limit : ffba_pkg::HEAP_BYTES;
  assign brk_end     = {2'b00, break_offset} + {2'b00, ffba_pkg::HDR_BYTES}
                       + {2'b00, req_q.size};
  assign split_need  = {1'b0, req_q.size} + {1'b0, ffba_pkg::HDR_BYTES} + (AddrW+1)'(1);
  assign split_start = {{(AddrW-StartW){1'b0}}, f_start} + ffba_pkg::HDR_BYTES + req_q.size;
  assign rem_size    = f_size - req_q.size - ffba_pkg::HDR_BYTES;
  assign grant_found = {{(AddrW-StartW){1'b0}}, f_start} + ffba_pkg::HDR_BYTES;
  assign grant_break = break_offset + ffba_pkg::HDR_BYTES;

  always_comb begin
    stat.op         = req_q.opcode;
    stat.size_zero  = (req_q.size == '0);
    stat.addr_null  = (req_q.address == '0);
    stat.list_valid = list_valid;
    stat.walk_done  = hit || at_tail;
    stat.found      = found;
    stat.block_ok   = (f_size != '0) && !f_free &&
                      ((f_tag == ffba_pkg::TAG_FRESH) || (f_tag == ffba_pkg::TAG_REUSED));
    stat.fits_old   = (f_size >= req_q.size);
    stat.table_full = (slot_count >= CntW'(MAX_BLOCKS));
    stat.can_split  = ({1'b0, f_size} >= split_need) && !stat.table_full;
    stat.heap_short = (brk_end > {2'b00, eff_limit});
  end

  always_comb begin
    we_start = 1'b0;
    we_size  = 1'b0;
    we_flag  = 1'b0;
    we_link  = 1'b0;
    waddr    = f_idx;
    w_start  = split_start[StartW-1:0];
    w_size   = req_q.size;
    w_flag   = {1'b0, ffba_pkg::TAG_REUSED};
    w_link   = slot_idx;
    unique case (cmd.wr)
      ffba_pkg::WR_NONE: begin
      end
      ffba_pkg::WR_SPLIT_OLD: begin
        we_size = 1'b1;
        we_flag = 1'b1;
        we_link = 1'b1;
      end
      ffba_pkg::WR_SPLIT_NEW: begin
        waddr    = slot_idx;
        we_start = 1'b1;
        we_size  = 1'b1;
        we_flag  = 1'b1;
        we_link  = 1'b1;
        w_size   = rem_size;
        w_flag   = {1'b1, ffba_pkg::TAG_FRESH};
        w_link   = f_link;
      end
      ffba_pkg::WR_MARK: begin
        we_flag = 1'b1;
      end
      ffba_pkg::WR_LINK: begin
        waddr   = tail_idx;
        we_link = 1'b1;
      end
      ffba_pkg::WR_APPEND: begin
        waddr    = slot_idx;
        we_start = 1'b1;
        we_size  = 1'b1;
        we_flag  = 1'b1;
        we_link  = 1'b1;
        w_start  = break_offset[StartW-1:0];
        w_flag   = {1'b0, ffba_pkg::TAG_FRESH};
        w_link   = '0;
      end
      ffba_pkg::WR_RELEASE: begin
        waddr   = o_idx;
        we_flag = 1'b1;
        w_flag  = {1'b1, ffba_pkg::TAG_FREED};
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit   <= ffba_pkg::HEAP_LIMIT_RST;
      list_valid   <= 1'b0;
      tail_idx     <= '0;
      slot_count   <= '0;
      break_offset <= '0;
      found        <= 1'b0;
    end else begin
      if (cfg_we) begin
        heap_limit <= cfg_wdata;
      end
      if (cmd.walk_init) begin
        found <= 1'b0;
      end else if (cmd.walk && hit) begin
        found <= 1'b1;
      end
      if (cmd.wr == ffba_pkg::WR_SPLIT_NEW) begin
        if (tail_idx == f_idx) begin
          tail_idx <= slot_idx;
        end
        slot_count <= slot_count + CntW'(1);
      end
      if (cmd.wr == ffba_pkg::WR_APPEND) begin
        tail_idx     <= slot_idx;
        list_valid   <= 1'b1;
        slot_count   <= slot_count + CntW'(1);
        break_offset <= brk_end[AddrW-1:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
      res   <= '0;
    end
    if (cmd.walk_init) begin
      mode    <= cmd.walk_mode;
      cur_idx <= '0;
    end else if (cmd.walk) begin
      cur_idx <= q_link;
      if (hit) begin
        f_idx   <= cur_idx;
        f_start <= q_start;
        f_size  <= q_size;
        f_free  <= q_flag[2];
        f_tag   <= q_flag[1:0];
        f_link  <= q_link;
      end
    end
    if (cmd.save_old) begin
      o_idx  <= f_idx;
      o_size <= f_size;
    end
    if (cmd.set_status) begin
      res.status <= cmd.status_code;
    end
    if (cmd.keep_addr) begin
      res.address_out <= req_q.address;
    end
    if ((cmd.wr == ffba_pkg::WR_SPLIT_OLD) || (cmd.wr == ffba_pkg::WR_MARK)) begin
      res.address_out <= grant_found;
    end
    if (cmd.wr == ffba_pkg::WR_APPEND) begin
      res.address_out <= grant_break;
    end
    if (cmd.set_moved) begin
      res.moved       <= 1'b1;
      res.copy_length <= o_size;
    end
  end

  assign rsp = res;

endmodule

`default_nettype wire

@@ design/ffba_ctrl.sv @@
`default_nettype none

module ffba_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output      logic            req_ready,
  output      logic            rsp_valid,
  input  wire logic            rsp_ready,
  input  wire ffba_pkg::stat_t stat,
  output      ffba_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE       = 13'b0000000000001,
    S_START      = 13'b0000000000010,
    S_WALK_FIND  = 13'b0000000000100,
    S_CHECK_FIND = 13'b0000000001000,
    S_WALK_FIT   = 13'b0000000010000,
    S_CHECK_FIT  = 13'b0000000100000,
    S_SPLIT_OLD  = 13'b0000001000000,
    S_SPLIT_NEW  = 13'b0000010000000,
    S_MARK       = 13'b0000100000000,
    S_LINK       = 13'b0001000000000,
    S_APPEND     = 13'b0010000000000,
    S_RELEASE    = 13'b0100000000000,
    S_RESP       = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   pending, pending_next;
  state_t after_grant;

  assign req_ready   = (state == S_IDLE);
  assign rsp_valid   = (state == S_RESP);
  assign after_grant = pending ? S_RELEASE : S_RESP;

  always_comb begin
    state_next   = state;
    pending_next = pending;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load     = 1'b1;
          pending_next = 1'b0;
          state_next   = S_START;
        end
      end
      S_START: begin
        if (stat.op == ffba_pkg::OP_NOP) begin
          state_next = S_RESP;
        end else if ((stat.op == ffba_pkg::OP_ALLOC) || stat.addr_null) begin
          if (stat.op == ffba_pkg::OP_FREE) begin
            state_next = S_RESP;
          end else if (stat.size_zero) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ffba_pkg::ST_ZERO;
            state_next      = S_RESP;
          end else begin
            cmd.walk_init = 1'b1;
            cmd.walk_mode = ffba_pkg::MODE_FIT;
            state_next    = stat.list_valid ? S_WALK_FIT : S_CHECK_FIT;
          end
        end else begin
          cmd.walk_init = 1'b1;
          cmd.walk_mode = ffba_pkg::MODE_FIND;
          state_next    = stat.list_valid ? S_WALK_FIND : S_CHECK_FIND;
        end
      end
      S_WALK_FIND: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_next = S_CHECK_FIND;
        end
      end
      S_CHECK_FIND: begin
        cmd.save_old = 1'b1;
        if (!stat.found || !stat.block_ok) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffba_pkg::ST_BADPTR;
          state_next      = S_RESP;
        end else if (stat.op == ffba_pkg::OP_FREE) begin
          state_next = S_RELEASE;
        end else if (stat.fits_old) begin
          cmd.keep_addr = 1'b1;
          state_next    = S_RESP;
        end else begin
          pending_next  = 1'b1;
          cmd.walk_init = 1'b1;
          cmd.walk_mode = ffba_pkg::MODE_FIT;
          state_next    = stat.list_valid ? S_WALK_FIT : S_CHECK_FIT;
        end
      end
      S_WALK_FIT: begin
        cmd.walk = 1'b1;
        if (stat.walk_done) begin
          state_next = S_CHECK_FIT;
        end
      end
      S_CHECK_FIT: begin
        if (stat.found) begin
          state_next = stat.can_split ? S_SPLIT_OLD : S_MARK;
        end else if (stat.table_full) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffba_pkg::ST_FULL;
          state_next      = S_RESP;
        end else if (stat.heap_short) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffba_pkg::ST_EXHAUSTED;
          state_next      = S_RESP;
        end else begin
          state_next = stat.list_valid ? S_LINK : S_APPEND;
        end
      end
      S_SPLIT_OLD: begin
        cmd.wr     = ffba_pkg::WR_SPLIT_OLD;
        state_next = S_SPLIT_NEW;
      end
      S_SPLIT_NEW: begin
        cmd.wr     = ffba_pkg::WR_SPLIT_NEW;
        state_next = after_grant;
      end
      S_MARK: begin
        cmd.wr     = ffba_pkg::WR_MARK;
        state_next = after_grant;
      end
      S_LINK: begin
        cmd.wr     = ffba_pkg::WR_LINK;
        state_next = S_APPEND;
      end
      S_APPEND: begin
        cmd.wr     = ffba_pkg::WR_APPEND;
        state_next = after_grant;
      end
      S_RELEASE: begin
        cmd.wr        = ffba_pkg::WR_RELEASE;
        cmd.set_moved = pending;
        state_next    = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

endmodule

`default_nettype wire

@@ design/first_fit_block_allocator.sv @@
// First-fit heap allocator over a linked table of blocks in address order.
// A request word (opcode, address, size) enters on req_valid/req_ready and
// one response word (address_out, status, moved, copy_length) leaves on
// rsp_valid/rsp_ready for every request. Requests are handled one at a time:
// req_ready is high only while the block waits for work.
// From one accepted request to the next, a request passes through the accept
// state, a decode state and one check state after each list walk, up to 3
// table write states and the response state. The walk reads one entry per
// cycle from the table memories; a reallocate that moves walks the list twice.
// The response word is held in registers and stays on rsp until taken; while
// the receiver stalls the block accepts nothing.
// The heap limit is written through cfg_we/cfg_wdata with no wait; write it
// only while the block is idle. Reset (synchronous, active high) empties the
// block list, clears the program break and sets the heap limit to 1 MiB. The
// table memories are not cleared: only entries linked into the list are read.
`default_nettype none

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output      logic                        req_ready,
  input  wire ffba_pkg::req_t              req,
  output      logic                        rsp_valid,
  input  wire logic                        rsp_ready,
  output      ffba_pkg::rsp_t              rsp,
  input  wire logic                        cfg_we,
  input  wire logic [ffba_pkg::ADDR_W-1:0] cfg_wdata
);

  // Command and status between the sequencer and the datapath.
  ffba_pkg::cmd_t  cmd;
  ffba_pkg::stat_t stat;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath owns the block table, the list bookkeeping, the program
  // break, the heap limit and the response registers.
  ffba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

  // A pending response blocks new requests.
  a_no_accept_while_responding : assert property (
    @(posedge clk) disable iff (rst) rsp_valid |-> !req_ready
  ) else $error("request accepted while a response is pending");

  // One request at a time: the cycle after an accept is busy.
  a_busy_after_accept : assert property (
    @(posedge clk) disable iff (rst) (req_valid && req_ready) |=> !req_ready
  ) else $error("ready stayed high after a request was accepted");

  // A move always comes with a successful grant.
  a_move_has_grant : assert property (
    @(posedge clk) disable iff (rst)
      (rsp_valid && rsp.moved) |-> (rsp.status == ffba_pkg::ST_OK && rsp.address_out != '0)
  ) else $error("move reported without a granted address");

  // A failed request grants nothing and asks for no copy.
  a_fail_is_empty : assert property (
    @(posedge clk) disable iff (rst)
      (rsp_valid && rsp.status != ffba_pkg::ST_OK) |->
        (rsp.address_out == '0 && rsp.copy_length == '0 && !rsp.moved)
  ) else $error("failed request carries a grant or copy length");

endmodule

`default_nettype wire

@@ verif/ffba_heap_checker.sv @@
module ffba_heap_checker
  import ffba_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic              req_ready,
  input  wire req_t              req,
  input  wire logic              rsp_valid,
  input  wire logic              rsp_ready,
  input  wire rsp_t              rsp,
  input  wire logic              cfg_we,
  input  wire logic [ADDR_W-1:0] cfg_wdata,
  output int                     errors,
  output int                     pending,
  output int                     checked,
  output int                     moves,
  output logic [7:0]             status_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB         = MAX_BLOCKS;
  localparam int IW         = $clog2(NB);
  localparam int HDR        = int'(HDR_BYTES);
  localparam int HEAP       = int'(HEAP_BYTES);

  // Shadow copy of the block table and the heap bookkeeping.
  logic [START_W-1:0] base_of [NB];
  logic [ADDR_W-1:0]  len_of  [NB];
  logic               is_free [NB];
  logic [1:0]         tag_of  [NB];
  logic [IW-1:0]      next_of [NB];
  logic               chain_live;
  logic [IW-1:0]      tail_slot;
  int                 used_slots;
  int                 brk;
  int                 limit_cfg;

  // Responses owed by the block, oldest first.
  rsp_t owed_rsp[$];

  // Walks the chain from slot 0: first free block of at least key bytes, or
  // the block whose data address equals key. Returns -1 when nothing matches.
  function automatic int find_block(input walk_mode_t mode, input int key);
    int idx;
    idx = 0;
    if (!chain_live) return -1;
    for (int n = 0; n < used_slots; n++) begin
      if (mode == MODE_FIT) begin
        if (is_free[idx] && int'(len_of[idx]) >= key) return idx;
      end else if (int'(base_of[idx]) + HDR == key) begin
        return idx;
      end
      if (idx == int'(tail_slot)) break;
      idx = int'(next_of[idx]);
    end
    return -1;
  endfunction

  function automatic bit holds_data(input int idx);
    return len_of[idx] != '0 && !is_free[idx] &&
           (tag_of[idx] == TAG_FRESH || tag_of[idx] == TAG_REUSED);
  endfunction

  function automatic void release_block(input int idx);
    is_free[idx] = 1'b1;
    tag_of[idx]  = TAG_FREED;
  endfunction

  // First fit with splitting, else growth of the break.
  function automatic status_t take_space(input int need, output logic [ADDR_W-1:0] grant);
    int idx;
    int nw;
    int lim;
    int top_end;
    grant = '0;
    if (need == 0) return ST_ZERO;
    idx = find_block(MODE_FIT, need);
    if (idx >= 0) begin
      if (int'(len_of[idx]) >= need + HDR + 1 && used_slots < NB) begin
        nw = used_slots;
        base_of[nw] = START_W'(int'(base_of[idx]) + HDR + need);
        len_of[nw]  = ADDR_W'(int'(len_of[idx]) - need - HDR);
        is_free[nw] = 1'b1;
        tag_of[nw]  = TAG_FRESH;
        next_of[nw] = next_of[idx];
        if (int'(tail_slot) == idx) tail_slot = IW'(nw);
        len_of[idx]  = ADDR_W'(need);
        next_of[idx] = IW'(nw);
        used_slots++;
      end
      is_free[idx] = 1'b0;
      tag_of[idx]  = TAG_REUSED;
      grant = ADDR_W'(int'(base_of[idx]) + HDR);
      return ST_OK;
    end
    if (used_slots >= NB) return ST_FULL;
    lim = (limit_cfg < HEAP) ? limit_cfg : HEAP;
    top_end = brk + HDR + need;
    if (top_end > lim) return ST_EXHAUSTED;
    nw = used_slots;
    base_of[nw] = START_W'(brk);
    len_of[nw]  = ADDR_W'(need);
    is_free[nw] = 1'b0;
    tag_of[nw]  = TAG_FRESH;
    next_of[nw] = '0;
    if (chain_live) next_of[tail_slot] = IW'(nw);
    tail_slot  = IW'(nw);
    chain_live = 1'b1;
    used_slots++;
    brk   = top_end;
    grant = ADDR_W'(int'(base_of[nw]) + HDR);
    return ST_OK;
  endfunction

  function automatic rsp_t serve_request(input req_t w);
    rsp_t r;
    int idx;
    logic [ADDR_W-1:0] g;
    r = '0;
    case (w.opcode)
      OP_ALLOC: begin
        r.status      = take_space(int'(w.size), g);
        r.address_out = g;
      end
      OP_FREE: begin
        if (w.address != '0) begin
          idx = find_block(MODE_FIND, int'(w.address));
          if (idx < 0 || !holds_data(idx)) r.status = ST_BADPTR;
          else release_block(idx);
        end
      end
      OP_REALLOC: begin
        if (w.address == '0) begin
          r.status      = take_space(int'(w.size), g);
          r.address_out = g;
        end else begin
          idx = find_block(MODE_FIND, int'(w.address));
          if (idx < 0 || !holds_data(idx)) begin
            r.status = ST_BADPTR;
          end else if (len_of[idx] >= w.size) begin
            r.address_out = w.address;
          end else begin
            r.status      = take_space(int'(w.size), g);
            r.address_out = g;
            if (r.status == ST_OK) begin
              r.copy_length = len_of[idx];
              r.moved       = 1'b1;
              release_block(idx);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [ADDR_W-1:0] want_v,
                             input logic [ADDR_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      chain_live  = 1'b0;
      tail_slot   = '0;
      used_slots  = 0;
      brk         = 0;
      limit_cfg   = int'(HEAP_LIMIT_RST);
      owed_rsp.delete();
      errors      = 0;
      pending     = 0;
      checked     = 0;
      moves       = 0;
      status_hits = '0;
    end else begin
      if (cfg_we) limit_cfg = int'(cfg_wdata);
      // Compare before predicting, so a response is never matched against
      // the request taken at the same edge.
      if (rsp_valid && rsp_ready) begin
        if (owed_rsp.size() == 0) begin
          errors++;
          $display("[%0t] response word with none expected: address_out %0d status %0d",
                   $time, rsp.address_out, rsp.status);
        end else begin
          want = owed_rsp.pop_front();
          check_field("address_out", want.address_out, rsp.address_out);
          check_field("status", ADDR_W'(want.status), ADDR_W'(rsp.status));
          check_field("moved", ADDR_W'(want.moved), ADDR_W'(rsp.moved));
          check_field("copy_length", want.copy_length, rsp.copy_length);
          checked++;
          if (want.moved) moves++;
          status_hits[int'(want.status)] = 1'b1;
        end
      end
      if (req_valid && req_ready) owed_rsp.push_back(serve_request(req));
      pending = owed_rsp.size();
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  // A handshake can be missing for at most one double list walk plus the
  // longest random stall on either side; this bound is many times that.
  localparam int QUIET_LIMIT      = 4000;
  // Longest request: a reallocate that moves walks the list twice.
  localparam int DRAIN_CYCLES     = 2 * MAX_BLOCKS + 8;
  localparam int RANDOM_PER_PHASE = 510;
  localparam int FULL_HEAP        = int'(HEAP_BYTES);

  logic              clk = 1'b0;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_t              rsp;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_wdata;

  int         errors;
  int         pending;
  int         checked;
  int         moves;
  logic [7:0] status_hits;

  int send_idle;
  int rcv_stall;
  int words_sent;
  int quiet;

  // Data addresses the block has handed out, used to build free and
  // reallocate words that actually hit live blocks.
  logic [ADDR_W-1:0] live_ptrs[$];
  req_t              last_taken;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_fit_block_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  ffba_heap_checker heap_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked),
    .moves       (moves),
    .status_hits (status_hits)
  );

  function automatic int ptr_slot(input logic [ADDR_W-1:0] a);
    for (int i = 0; i < live_ptrs.size(); i++)
      if (live_ptrs[i] == a) return i;
    return -1;
  endfunction

  // Keep the pointer pool in step with what the block grants. The block
  // takes one request at a time, so a response belongs to the last request
  // word taken. A reallocate that moved has freed its old block.
  always @(posedge clk) begin : track_ptrs
    int i;
    if (req_valid && req_ready) last_taken <= req;
    if (rsp_valid && rsp_ready && rsp.status == ST_OK && rsp.address_out != '0) begin
      if (last_taken.opcode == OP_REALLOC && rsp.moved) begin
        i = ptr_slot(last_taken.address);
        if (i >= 0) live_ptrs.delete(i);
      end
      if (ptr_slot(rsp.address_out) < 0 && live_ptrs.size() < 96)
        live_ptrs.push_back(rsp.address_out);
    end
  end

  // The receiver stalls at random; the rate changes per phase.
  always @(negedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rcv_stall);
  end

  // Watchdog: count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("[%0t] no word accepted for %0d cycles, giving up", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Presents one request word from a falling edge and holds it until the
  // block takes it. Returns at the falling edge after acceptance, with valid
  // still high so a following word can go out back to back.
  task automatic send_word(input req_t w);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drive(input opcode_t op, input int a, input int s);
    req_t w;
    w.opcode  = op;
    w.address = ADDR_W'(a);
    w.size    = ADDR_W'(s);
    send_word(w);
  endtask

  // The heap limit may only change while the block is idle, that is once
  // every response owed has come back.
  task automatic set_limit(input int v);
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= ADDR_W'(v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small requests so blocks get reused and split; the rare large
  // ones push the break into the limit.
  function automatic logic [ADDR_W-1:0] rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 72) return ADDR_W'($urandom_range(256, 1));
    if (r < 94) return ADDR_W'($urandom_range(4096, 257));
    if (r < 99) return ADDR_W'($urandom_range(65536, 4097));
    return ADDR_W'($urandom_range(FULL_HEAP, 65537));
  endfunction

  // Picks a granted pointer. A free usually retires it from the pool; the
  // rest are kept to produce double frees. Now and then the pointer is
  // nudged by one byte so it lands inside a block instead of at its start.
  function automatic logic [ADDR_W-1:0] pick_ptr(input bit releasing);
    int i;
    logic [ADDR_W-1:0] a;
    if (live_ptrs.size() == 0) return '0;
    i = $urandom_range(live_ptrs.size() - 1);
    a = live_ptrs[i];
    if ($urandom_range(99) < 4) return a + 1'b1;
    if (releasing && $urandom_range(99) < 85) live_ptrs.delete(i);
    return a;
  endfunction

  // Most words are well formed; about one in twelve is pure noise over the
  // whole field ranges, including the idle opcode.
  function automatic req_t next_word();
    req_t w;
    int r;
    r = $urandom_range(99);
    w.opcode  = OP_ALLOC;
    w.address = '0;
    w.size    = rand_size();
    if (r < 8) begin
      w.opcode  = opcode_t'($urandom_range(3));
      w.address = ADDR_W'($urandom_range(FULL_HEAP));
      w.size    = ADDR_W'($urandom_range(FULL_HEAP));
    end else if (r >= 44 && r < 74) begin
      w.opcode  = OP_FREE;
      w.address = ($urandom_range(19) == 0) ? '0 : pick_ptr(1'b1);
    end else if (r >= 74) begin
      w.opcode  = OP_REALLOC;
      w.address = ($urandom_range(9) == 0) ? '0 : pick_ptr(1'b0);
    end
    return w;
  endfunction

  initial begin
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    send_idle  = 38;
    rcv_stall  = 55;
    words_sent = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Zero limit: every append runs out of heap. Also the empty-list and
    // null-pointer cases and the idle opcode with address and size at the full heap size.
    set_limit(0);
    drive(OP_ALLOC, 0, 1);
    drive(OP_ALLOC, 0, 0);
    drive(OP_FREE, 0, 0);
    drive(OP_FREE, 24, 0);
    drive(OP_REALLOC, 0, 0);
    drive(OP_REALLOC, 0, 5);
    drive(OP_NOP, FULL_HEAP, FULL_HEAP);

    // A 100 byte heap holds exactly one block of 76 bytes. Resize in place,
    // double free, reuse with a split, an exact fit, a pointer that hits no
    // block, and a reallocate that cannot grow.
    set_limit(100);
    drive(OP_ALLOC, 0, 76);
    drive(OP_ALLOC, 0, 1);
    drive(OP_REALLOC, 24, 76);
    drive(OP_REALLOC, 24, 0);
    drive(OP_FREE, 24, 0);
    drive(OP_FREE, 24, 0);
    drive(OP_REALLOC, 24, 4);
    drive(OP_ALLOC, 0, 10);
    drive(OP_ALLOC, 0, 42);
    drive(OP_FREE, 83, 0);
    drive(OP_REALLOC, 24, 500);

    // Full heap: the largest request still fails, then a real move.
    set_limit(FULL_HEAP);
    drive(OP_REALLOC, 24, FULL_HEAP);
    drive(OP_REALLOC, 24, 1000);
    drive(OP_FREE, 82, 0);
    drive(OP_ALLOC, 0, FULL_HEAP);
    drive(OP_ALLOC, 0, 30);

    // Random phases. The table never shrinks, so the first phase fills it
    // and the later ones live on reuse, whole-block grants and table-full.
    for (int p = 0; p < 3; p++) begin
      set_limit((p == 0) ? $urandom_range(40000, 3000) :
                (p == 1) ? FULL_HEAP : $urandom_range(FULL_HEAP));
      send_idle = (p == 0) ? 38 : (p == 1) ? 55 : 0;
      rcv_stall = (p == 0) ? 55 : (p == 1) ? 38 : 0;
      repeat (RANDOM_PER_PHASE) send_word(next_word());
    end

    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // Let any stray response show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Drove %0d request words over five heap limits, zero and full among them.",
             words_sent);
    $display("Checked %0d response words, %0d of them moves; status codes seen: %b.",
             checked, moves, status_hits[4:0]);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
